FILE: sv/cgng_pkg.sv
// Shared types, codes and defaults for the neighbour gather block.
`default_nettype none
package cgng_pkg;
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_EDGES_DEF    = 4096;
	localparam int MAX_RUN_DEF      = 64;

	localparam logic [2:0] REQ_OUT_START = 3'd0;
	localparam logic [2:0] REQ_IN_START  = 3'd1;
	localparam logic [2:0] REQ_OUT_ORDER = 3'd2;
	localparam logic [2:0] REQ_IN_ORDER  = 3'd3;
	localparam logic [2:0] REQ_EDGE_SRC  = 3'd4;
	localparam logic [2:0] REQ_EDGE_TGT  = 3'd5;
	localparam logic [2:0] REQ_NEIGHBORS = 3'd6;
	localparam logic [2:0] REQ_CONTAINS  = 3'd7;

	localparam logic [1:0] DIR_OUT  = 2'd0;
	localparam logic [1:0] DIR_IN   = 2'd1;
	localparam logic [1:0] DIR_BOTH = 2'd2;
	localparam logic [1:0] DIR_UNIQ = 2'd3;

	localparam logic CFG_DIRECTED = 1'b0;
	localparam logic CFG_VCOUNT   = 1'b1;

	// decoded word handed from the front end to the walker
	typedef struct packed {
		logic [2:0]  req;
		logic [11:0] slot;
		logic [12:0] value;
		logic [9:0]  vertex;
		logic [9:0]  other;
		logic        is_query;
		logic        contains;
		logic        bad;
		logic        en_out;
		logic        en_in;
		logic        merge;
		logic        tie_both;
		logic        norepeat;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ST0,
		ST_ST1,
		ST_ST2,
		ST_ORD,
		ST_EDG,
		ST_CMP,
		ST_TIE,
		ST_RES,
		ST_DRN,
		ST_LD
	} walk_state_t;
endpackage
`default_nettype wire

FILE: sv/cgng_front.sv
// Front end: decodes input words and holds them in a two-entry queue.
`default_nettype none
module cgng_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire logic          graph_directed,
	input  wire logic [10:0]   vertex_count,
	input  wire logic [2:0]    req_type,
	input  wire logic [11:0]   slot,
	input  wire logic [12:0]   value,
	input  wire logic [9:0]    vertex,
	input  wire logic [9:0]    other_vertex,
	input  wire logic [1:0]    direction,
	output cgng_pkg::cmd_t     cq_data,
	output logic               cq_valid,
	input  wire logic          cq_take
);
	import cgng_pkg::*;

	cmd_t       cls;
	logic [1:0] dir_eff;
	logic       push_ok;
	cmd_t       fifo_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	// undirected graphs always walk both lists back to back
	always_comb begin
		dir_eff      = graph_directed ? direction : DIR_BOTH;
		cls.req      = req_type;
		cls.slot     = slot;
		cls.value    = value;
		cls.vertex   = vertex;
		cls.other    = other_vertex;
		cls.is_query = (req_type == REQ_NEIGHBORS) || (req_type == REQ_CONTAINS);
		cls.contains = (req_type == REQ_CONTAINS);
		cls.bad      = ({1'b0, vertex} >= vertex_count) ||
			((req_type == REQ_CONTAINS) && ({1'b0, other_vertex} >= vertex_count));
		cls.en_out   = (dir_eff != DIR_IN);
		cls.en_in    = (dir_eff != DIR_OUT);
		cls.merge    = (dir_eff == DIR_UNIQ) || ((dir_eff == DIR_BOTH) && graph_directed);
		cls.tie_both = (dir_eff != DIR_UNIQ);
		cls.norepeat = (dir_eff == DIR_UNIQ);
	end

	assign full     = (cnt_q == 2'd2);
	assign push_ok  = push && !full;
	assign cq_valid = (cnt_q != 2'd0);
	assign cq_data  = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			fifo_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_ok) begin
				wp_q <= !wp_q;
			end
			if (cq_take) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(push_ok) - 2'(cq_take);
		end
	end
endmodule
`default_nettype wire

FILE: sv/cgng_walk.sv
// Back end: table memories, adjacency walker, run buffer and result register.
`default_nettype none
module cgng_walk #(
	parameter int MAX_VERTICES = cgng_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = cgng_pkg::MAX_EDGES_DEF,
	parameter int MAX_RUN      = cgng_pkg::MAX_RUN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cgng_pkg::cmd_t cq_data,
	input  wire logic          cq_valid,
	output logic               cq_take,
	output logic               empty,
	input  wire logic          pop,
	output logic [9:0]         neighbor,
	output logic               has_item,
	output logic               is_last,
	output logic               found,
	output logic               bad_vertex,
	output logic               truncated
);
	import cgng_pkg::*;

	localparam int VA = $clog2(MAX_VERTICES + 1);
	localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int RA = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
	localparam int LW = $clog2(MAX_RUN + 1);

	logic [12:0] out_start_m [MAX_VERTICES + 1];
	logic [12:0] in_start_m  [MAX_VERTICES + 1];
	logic [11:0] out_order_m [MAX_EDGES];
	logic [11:0] in_order_m  [MAX_EDGES];
	logic [9:0]  edge_src_m  [MAX_EDGES];
	logic [9:0]  edge_tgt_m  [MAX_EDGES];
	logic [9:0]  run_m       [MAX_RUN];

	walk_state_t state_q, state_d;
	cmd_t        cmd_q;
	logic [12:0] i1_q, j1_q, i2_q, j2_q;
	logic [LW-1:0] len_q, k_q;
	logic        cut_q, hit_q, hl_q;
	logic [9:0]  last_q, tie_q;

	logic [12:0] os_rd_q, is_rd_q;
	logic        sz_q;
	logic [11:0] oo_rd_q, io_rd_q;
	logic        oz1_q, oz2_q;
	logic [9:0]  et_rd_q, es_rd_q;
	logic        nz1_q, nz2_q;
	logic [9:0]  buf_rd_q;

	logic        out_v_q;
	logic [9:0]  nb_q;
	logic        has_q, last_r_q, found_q, bad_q, trunc_q;

	logic [31:0] slot32, st_idx, i1_32, i2_32, e1_32, e2_32;
	logic        wr_go, sv_ok;
	logic [12:0] st1, st2;
	logic [11:0] e1, e2;
	logic [9:0]  n1, n2;
	logic        a1, a2, em_go, adv1, adv2, tie_go, done;
	logic [9:0]  em_val;
	logic        skip, keep, buf_we, cut_now, d_last;

	// ---------------- addressing
	assign wr_go  = cq_take && !cq_data.is_query;
	assign slot32 = 32'(cq_data.slot);
	assign st_idx = (state_q == ST_ST1) ? 32'(cmd_q.vertex) + 32'd1 : 32'(cmd_q.vertex);
	assign sv_ok  = (st_idx <= 32'(MAX_VERTICES));
	assign st1    = sz_q ? 13'd0 : os_rd_q;
	assign st2    = sz_q ? 13'd0 : is_rd_q;
	assign i1_32  = 32'(i1_q);
	assign i2_32  = 32'(i2_q);
	// an order index past the table reads as edge zero
	assign e1     = oz1_q ? 12'd0 : oo_rd_q;
	assign e2     = oz2_q ? 12'd0 : io_rd_q;
	assign e1_32  = 32'(e1);
	assign e2_32  = 32'(e2);
	assign n1     = nz1_q ? 10'd0 : et_rd_q;
	assign n2     = nz2_q ? 10'd0 : es_rd_q;

	// ---------------- memories
	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_OUT_START) && (slot32 <= 32'(MAX_VERTICES))) begin
			out_start_m[slot32[VA-1:0]] <= cq_data.value;
		end
		os_rd_q <= out_start_m[st_idx[VA-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_IN_START) && (slot32 <= 32'(MAX_VERTICES))) begin
			in_start_m[slot32[VA-1:0]] <= cq_data.value;
		end
		is_rd_q <= in_start_m[st_idx[VA-1:0]];
		sz_q    <= !sv_ok;
	end

	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_OUT_ORDER) && (slot32 < 32'(MAX_EDGES))) begin
			out_order_m[slot32[EA-1:0]] <= cq_data.value[11:0];
		end
		oo_rd_q <= out_order_m[i1_32[EA-1:0]];
		oz1_q   <= !(i1_32 < 32'(MAX_EDGES));
	end

	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_IN_ORDER) && (slot32 < 32'(MAX_EDGES))) begin
			in_order_m[slot32[EA-1:0]] <= cq_data.value[11:0];
		end
		io_rd_q <= in_order_m[i2_32[EA-1:0]];
		oz2_q   <= !(i2_32 < 32'(MAX_EDGES));
	end

	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_EDGE_TGT) && (slot32 < 32'(MAX_EDGES))) begin
			edge_tgt_m[slot32[EA-1:0]] <= cq_data.value[9:0];
		end
		et_rd_q <= edge_tgt_m[e1_32[EA-1:0]];
		nz1_q   <= !(e1_32 < 32'(MAX_EDGES));
	end

	always_ff @(posedge clk) begin
		if (wr_go && (cq_data.req == REQ_EDGE_SRC) && (slot32 < 32'(MAX_EDGES))) begin
			edge_src_m[slot32[EA-1:0]] <= cq_data.value[9:0];
		end
		es_rd_q <= edge_src_m[e2_32[EA-1:0]];
		nz2_q   <= !(e2_32 < 32'(MAX_EDGES));
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			run_m[len_q[RA-1:0]] <= em_val;
		end
		buf_rd_q <= run_m[k_q[RA-1:0]];
	end

	// ---------------- step decision and emit filter
	always_comb begin
		a1     = cmd_q.en_out && (i1_q < j1_q);
		a2     = cmd_q.en_in && (i2_q < j2_q);
		em_go  = 1'b0;
		em_val = n1;
		adv1   = 1'b0;
		adv2   = 1'b0;
		tie_go = 1'b0;
		done   = 1'b0;
		if (state_q == ST_TIE) begin
			em_go  = 1'b1;
			em_val = tie_q;
		end else if (state_q == ST_CMP) begin
			if (cmd_q.merge && a1 && a2) begin
				em_go = 1'b1;
				if (n1 < n2) begin
					adv1 = 1'b1;
				end else if (n2 < n1) begin
					em_val = n2;
					adv2   = 1'b1;
				end else begin
					adv1   = 1'b1;
					adv2   = 1'b1;
					tie_go = cmd_q.tie_both;
				end
			end else if (a1) begin
				em_go = 1'b1;
				adv1  = 1'b1;
			end else if (a2) begin
				em_go  = 1'b1;
				em_val = n2;
				adv2   = 1'b1;
			end else begin
				done = 1'b1;
			end
		end
		skip    = cmd_q.norepeat && ((em_val == cmd_q.vertex) || (hl_q && (em_val == last_q)));
		keep    = em_go && !skip;
		buf_we  = keep && !cmd_q.contains && (32'(len_q) < 32'(MAX_RUN));
		cut_now = keep && !cmd_q.contains && !(32'(len_q) < 32'(MAX_RUN));
		d_last  = (32'(k_q) + 32'd1 == 32'(len_q));
	end

	// ---------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cq_valid && cq_data.is_query) begin
					state_d = cq_data.bad ? ST_RES : ST_ST0;
				end
			end
			ST_ST0: state_d = ST_ST1;
			ST_ST1: state_d = ST_ST2;
			ST_ST2: state_d = ST_ORD;
			ST_ORD: state_d = ST_EDG;
			ST_EDG: state_d = ST_CMP;
			ST_CMP: begin
				if (done) begin
					state_d = (cmd_q.contains || (len_q == '0)) ? ST_RES : ST_DRN;
				end else if (cut_now) begin
					state_d = ST_DRN;
				end else if (tie_go) begin
					state_d = ST_TIE;
				end else begin
					state_d = ST_ORD;
				end
			end
			ST_TIE: state_d = cut_now ? ST_DRN : ST_ORD;
			ST_RES: begin
				if (!out_v_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRN: begin
				if (!out_v_q) begin
					state_d = ST_LD;
				end
			end
			ST_LD: state_d = d_last ? ST_IDLE : ST_DRN;
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer
	always_comb begin
		cq_take = (state_q == ST_IDLE) && cq_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			k_q     <= '0;
			cut_q   <= 1'b0;
			hit_q   <= 1'b0;
			hl_q    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cq_take) begin
				len_q <= '0;
				k_q   <= '0;
				cut_q <= 1'b0;
				hit_q <= 1'b0;
				hl_q  <= 1'b0;
			end
			if (keep) begin
				hl_q <= 1'b1;
				if (cmd_q.contains && (em_val == cmd_q.other)) begin
					hit_q <= 1'b1;
				end
			end
			if (buf_we) begin
				len_q <= len_q + LW'(1);
			end
			if (cut_now) begin
				cut_q <= 1'b1;
			end
			if (state_q == ST_LD) begin
				k_q <= k_q + LW'(1);
			end
			if (((state_q == ST_RES) && !out_v_q) || (state_q == ST_LD)) begin
				out_v_q <= 1'b1;
			end else if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cq_take) begin
			cmd_q <= cq_data;
		end
		if (state_q == ST_ST1) begin
			i1_q <= st1;
			i2_q <= st2;
		end
		if (state_q == ST_ST2) begin
			j1_q <= st1;
			j2_q <= st2;
		end
		if (adv1) begin
			i1_q <= i1_q + 13'd1;
		end
		if (adv2) begin
			i2_q <= i2_q + 13'd1;
		end
		if (keep) begin
			last_q <= em_val;
		end
		if (tie_go) begin
			tie_q <= n1;
		end
		if ((state_q == ST_RES) && !out_v_q) begin
			nb_q     <= 10'd0;
			has_q    <= 1'b0;
			last_r_q <= 1'b1;
			found_q  <= cmd_q.contains && !cmd_q.bad && hit_q;
			bad_q    <= cmd_q.bad;
			trunc_q  <= 1'b0;
		end else if (state_q == ST_LD) begin
			nb_q     <= buf_rd_q;
			has_q    <= 1'b1;
			last_r_q <= d_last;
			found_q  <= 1'b0;
			bad_q    <= 1'b0;
			trunc_q  <= cut_q;
		end
	end

	assign empty      = !out_v_q;
	assign neighbor   = nb_q;
	assign has_item   = has_q;
	assign is_last    = last_r_q;
	assign found      = found_q;
	assign bad_vertex = bad_q;
	assign truncated  = trunc_q;

	// ---------------- checks
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(len_q) <= 32'(MAX_RUN))
		else $error("run length beyond buffer");
	a_cut_full: assert property (@(posedge clk) disable iff (!arst_n)
		cut_q |-> (32'(len_q) == 32'(MAX_RUN)))
		else $error("run cut before buffer full");
	a_ld_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LD) |-> !out_v_q)
		else $error("result register overwritten");
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRN) || (state_q == ST_LD)) |-> (len_q != '0))
		else $error("drain of an empty run");
endmodule
`default_nettype wire

FILE: sv/csr_graph_neighbor_gather.sv
// Top level of the neighbour gather block: configuration registers and the two halves.
//
// Input channel: a word is taken on a rising edge with push high and full low.
// Table writes (request codes 0..5) give no result; queries (6 neighbours,
// 7 contains) give one or more result words.
// Result channel: the oldest result sits on the ports while empty is low and
// leaves on an edge with pop high. A stalled receiver simply holds the result
// register; the walker waits and the two-entry input queue fills, then full rises.
// Config channel: cfg_valid/cfg_ready, always ready; index 0 graph_directed,
// index 1 vertex_count. Write only while the block is idle.
// Sequence: a table write is taken from the queue head while the walker is idle.
// A query fetches its offsets in states ST0, ST1 and ST2, then walks in adjacency
// steps (order table read, edge table read, compare) plus a tie state on a directed
// tie, then loads each result word out of the run buffer once the result register
// is free. The chained order/edge memory reads set the step length.
// Reset: queue empty, no result pending, graph_directed 1, vertex_count 0.
// Table memories are not cleared and must be written before use.
`default_nettype none
module csr_graph_neighbor_gather #(
	parameter int MAX_VERTICES = cgng_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES    = cgng_pkg::MAX_EDGES_DEF,
	parameter int MAX_RUN      = cgng_pkg::MAX_RUN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  req_type,
	input  wire logic [11:0] slot,
	input  wire logic [12:0] value,
	input  wire logic [9:0]  vertex,
	input  wire logic [9:0]  other_vertex,
	input  wire logic [1:0]  direction,
	output logic             empty,
	input  wire logic        pop,
	output logic [9:0]       neighbor,
	output logic             has_item,
	output logic             is_last,
	output logic             found,
	output logic             bad_vertex,
	output logic             truncated,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data
);
	import cgng_pkg::*;

	logic        directed_q;
	logic [10:0] vcount_q;
	cmd_t        cq_data;
	logic        cq_valid;
	logic        cq_take;

	assign cfg_ready = 1'b1;

	// config word is registered on an edge with cfg_valid high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directed_q <= 1'b1;
			vcount_q   <= 11'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIRECTED: directed_q <= cfg_data[0];
				CFG_VCOUNT:   vcount_q   <= cfg_data;
				default:      vcount_q   <= vcount_q;
			endcase
		end
	end

	cgng_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.graph_directed (directed_q),
		.vertex_count   (vcount_q),
		.req_type       (req_type),
		.slot           (slot),
		.value          (value),
		.vertex         (vertex),
		.other_vertex   (other_vertex),
		.direction      (direction),
		.cq_data        (cq_data),
		.cq_valid       (cq_valid),
		.cq_take        (cq_take)
	);

	cgng_walk #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES),
		.MAX_RUN      (MAX_RUN)
	) u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cq_data    (cq_data),
		.cq_valid   (cq_valid),
		.cq_take    (cq_take),
		.empty      (empty),
		.pop        (pop),
		.neighbor   (neighbor),
		.has_item   (has_item),
		.is_last    (is_last),
		.found      (found),
		.bad_vertex (bad_vertex),
		.truncated  (truncated)
	);
endmodule
`default_nettype wire
